[rtl/core/lpt_pkg.sv]
// shared types and constants of the line protocol tokenizer
package lpt_pkg;

	localparam int MAX_WORD = 32;
	localparam int LEN_W    = $clog2(MAX_WORD + 1);
	localparam int ADDR_W   = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
	localparam int NUM_W    = 31;
	localparam int ACC_W    = NUM_W + 4;
	localparam int M_DATA_W = 40;
	localparam int M_USER_W = 4;

	localparam logic [NUM_W-1:0] NUM_MAX = 31'h7FFF_FFFF;

	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_0   = 8'h30;
	localparam logic [7:0] CH_9   = 8'h39;

	typedef enum logic [2:0] {
		K_CHAR  = 3'd0,
		K_NUM   = 3'd1,
		K_WRONG = 3'd2,
		K_EOL   = 3'd3,
		K_ERR   = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WORD,
		ST_DIGITS,
		ST_EOLN,
		ST_ERROR,
		ST_DUMP_SEP,
		ST_DUMP_CR
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic  clear;
		logic  keep;
		logic  accum;
		logic  dump_start;
		logic  dump_adv;
		logic  load;
		kind_t load_kind;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_lf;
		logic is_cr;
		logic is_sep;
		logic is_digit;
		logic out_free;
		logic dump_last;
	} sts_t;

endpackage

[rtl/core/line_protocol_tokenizer_core.sv]
// top level of the line protocol tokenizer
//
// byte stream in on s_tvalid/s_tready/s_tdata, one character per transaction.
// token stream out on m_tvalid/m_tready/m_tdata/m_tuser/m_tlast, one result
// per transaction: word characters, numbers, wrong numbers, end of line, errors.
// m_tlast marks the final result of a token and is always set on non-words.
// a number, end of line or error is presented in the cycle after the byte
// that completes it; the first character of a word follows once the word
// dump has begun and the result register is free. a space, tab or CR that
// ends a word stalls the input while the stored characters are read from
// the word memory and sent one per cycle when the receiver is ready.
// outside a word dump the input is taken whenever the single result register
// is empty or is being emptied in the same cycle; a stalled receiver
// therefore stalls the input after at most one pending result.
// asynchronous reset returns to the start state with no token pending;
// the word memory needs no clearing since only written entries are read.
module line_protocol_tokenizer_core
	import lpt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,  // byte_req
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // number[30:0], character[38:31]
	output logic [M_USER_W-1:0] m_tuser,  // kind[2:0], truncated[3]
	output logic                m_tlast
);

	cmd_t cmd;
	sts_t sts;

	lpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lpt_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

[rtl/core/lpt_datapath.sv]
// tokenizer datapath: byte classes, word memory, accumulator, output register
module lpt_datapath
	import lpt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          s_tdata,
	input  cmd_t                cmd,
	output sts_t                sts,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,
	output logic [M_USER_W-1:0] m_tuser,
	output logic                m_tlast
);

	logic [7:0]       mem_q [MAX_WORD];
	logic [7:0]       rd_data_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] idx_q;
	logic [LEN_W-1:0] idx_d;
	logic [NUM_W-1:0] acc_q;
	logic             ovf_q;
	logic             cut_q;

	logic [LEN_W-1:0] len_b;
	logic [NUM_W-1:0] acc_b;
	logic             ovf_b;
	logic             cut_b;
	logic [NUM_W-1:0] acc_d;
	logic             ovf_d;
	logic             wr_en;
	logic [3:0]       digit;
	logic [ACC_W-1:0] prod_v;

	logic             m_tvalid_q;
	kind_t            kind_q;
	logic [NUM_W-1:0] num_q;
	logic [7:0]       char_q;
	logic             last_q;
	logic             trunc_q;

	always_comb begin
		sts.is_lf     = (s_tdata == CH_LF);
		sts.is_cr     = (s_tdata == CH_CR);
		sts.is_sep    = (s_tdata == CH_SP) || (s_tdata == CH_TAB);
		sts.is_digit  = (s_tdata >= CH_0) && (s_tdata <= CH_9);
		sts.out_free  = !m_tvalid_q || m_tready;
		sts.dump_last = ((idx_q + LEN_W'(1)) == len_q);
	end

	// token state as seen after an optional clear in the same transaction
	always_comb begin
		len_b  = cmd.clear ? '0 : len_q;
		acc_b  = cmd.clear ? '0 : acc_q;
		ovf_b  = cmd.clear ? 1'b0 : ovf_q;
		cut_b  = cmd.clear ? 1'b0 : cut_q;
		wr_en  = cmd.keep && (len_b < LEN_W'(MAX_WORD));
		digit  = 4'(s_tdata - CH_0);
		prod_v = {1'b0, acc_b, 3'b000} + {3'b000, acc_b, 1'b0}
			+ {{NUM_W{1'b0}}, digit};
		acc_d  = acc_b;
		ovf_d  = ovf_b;
		if (cmd.accum && !ovf_b) begin
			if (prod_v > {4'b0000, NUM_MAX}) begin
				ovf_d = 1'b1;
			end else begin
				acc_d = prod_v[NUM_W-1:0];
			end
		end
	end

	always_comb begin
		if (cmd.dump_start) begin
			idx_d = '0;
		end else if (cmd.dump_adv) begin
			idx_d = idx_q + LEN_W'(1);
		end else begin
			idx_d = idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			idx_q <= '0;
			acc_q <= '0;
			ovf_q <= 1'b0;
			cut_q <= 1'b0;
		end else begin
			idx_q <= idx_d;
			len_q <= wr_en ? len_b + LEN_W'(1) : len_b;
			cut_q <= cut_b || (cmd.keep && !wr_en);
			acc_q <= acc_d;
			ovf_q <= ovf_d;
		end
	end

	// word memory, read address runs one step ahead of idx_q
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[len_b[ADDR_W-1:0]] <= s_tdata;
		end
		rd_data_q <= mem_q[idx_d[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load || cmd.dump_adv) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.dump_adv) begin
			kind_q  <= K_CHAR;
			num_q   <= '0;
			char_q  <= rd_data_q;
			last_q  <= sts.dump_last;
			trunc_q <= cut_q;
		end else if (cmd.load) begin
			kind_q  <= (cmd.load_kind == K_NUM && ovf_q) ? K_WRONG : cmd.load_kind;
			num_q   <= (cmd.load_kind == K_NUM && !ovf_q) ? acc_q : '0;
			char_q  <= '0;
			last_q  <= 1'b1;
			trunc_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {{(M_DATA_W - 39){1'b0}}, char_q, num_q};
	assign m_tuser  = {trunc_q, kind_q};

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load || cmd.dump_adv) |-> sts.out_free)
		else $error("result register overwritten while pending");

	a_dump_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.dump_start || cmd.dump_adv) |-> (len_q != '0))
		else $error("word dump on empty store");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_WORD))
		else $error("word length beyond store");

	a_cut_full: assert property (@(posedge clk) disable iff (!arst_n)
		cut_q |-> (len_q == LEN_W'(MAX_WORD)))
		else $error("cut-off flag set with room left");

	a_clear_len: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.clear && !cmd.keep) |=> (len_q == '0))
		else $error("token clear left characters");

endmodule

[rtl/core/lpt_ctrl.sv]
// tokenizer controller: lexer mode and word dump sequencing
module lpt_ctrl
	import lpt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.load_kind = K_ERR;
		s_tready      = 1'b0;
		accept        = 1'b0;
		case (state_q)
			ST_IDLE, ST_WORD, ST_DIGITS, ST_EOLN, ST_ERROR: begin
				s_tready = sts.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
		accept = s_tvalid && s_tready;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (sts.is_lf) begin
						cmd.load = 1'b1;
						state_d  = ST_ERROR;
					end else if (sts.is_sep) begin
						state_d = ST_IDLE;
					end else if (sts.is_digit) begin
						cmd.clear = 1'b1;
						cmd.keep  = 1'b1;
						cmd.accum = 1'b1;
						state_d   = ST_DIGITS;
					end else if (sts.is_cr) begin
						state_d = ST_EOLN;
					end else begin
						cmd.clear = 1'b1;
						cmd.keep  = 1'b1;
						state_d   = ST_WORD;
					end
				end
			end
			ST_WORD: begin
				if (accept) begin
					if (sts.is_lf) begin
						cmd.clear = 1'b1;
						cmd.load  = 1'b1;
						state_d   = ST_ERROR;
					end else if (sts.is_sep) begin
						cmd.dump_start = 1'b1;
						state_d        = ST_DUMP_SEP;
					end else if (sts.is_cr) begin
						cmd.dump_start = 1'b1;
						state_d        = ST_DUMP_CR;
					end else begin
						cmd.keep = 1'b1;
					end
				end
			end
			ST_DIGITS: begin
				if (accept) begin
					if (sts.is_lf) begin
						cmd.clear = 1'b1;
						cmd.load  = 1'b1;
						state_d   = ST_ERROR;
					end else if (sts.is_sep || sts.is_cr) begin
						cmd.load      = 1'b1;
						cmd.load_kind = K_NUM;
						cmd.clear     = 1'b1;
						state_d       = sts.is_cr ? ST_EOLN : ST_IDLE;
					end else if (sts.is_digit) begin
						cmd.keep  = 1'b1;
						cmd.accum = 1'b1;
					end else begin
						// digits collected so far open the word
						cmd.keep = 1'b1;
						state_d  = ST_WORD;
					end
				end
			end
			ST_EOLN: begin
				if (accept) begin
					cmd.load = 1'b1;
					if (sts.is_lf) begin
						cmd.load_kind = K_EOL;
						state_d       = ST_IDLE;
					end else begin
						state_d = ST_ERROR;
					end
				end
			end
			ST_ERROR: begin
				if (accept) begin
					cmd.load = 1'b1;
				end
			end
			ST_DUMP_SEP, ST_DUMP_CR: begin
				if (sts.out_free) begin
					cmd.dump_adv = 1'b1;
					if (sts.dump_last) begin
						cmd.clear = 1'b1;
						state_d   = (state_q == ST_DUMP_CR) ? ST_EOLN : ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_ERROR;
			end
		endcase
	end

endmodule
